// ===== src/arp_rsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_rsm_pkg
// Shared types and constants of the ARP reply spoofing monitor.
// ----------------------------------------------------------------------------
package arp_rsm_pkg;

	// Size of the IP-to-MAC binding table.
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	// Fixed widths of the reported fields.
	localparam int IDX_OUT_W = 6;
	localparam int CNT_OUT_W = 7;

	localparam int MAC_W  = 48;
	localparam int IP_W   = 32;
	localparam int TIME_W = 63;
	localparam int MD_W   = MAC_W + TIME_W;

	// Header values of a well-formed Ethernet / IPv4 ARP reply.
	localparam logic [15:0] MIN_PACKET_LEN = 16'd28;
	localparam logic [15:0] HW_ETHERNET    = 16'h0001;
	localparam logic [15:0] PROTO_IPV4     = 16'h0800;
	localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
	localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
	localparam logic [15:0] OP_REPLY       = 16'h0002;

	localparam logic [31:0] WINDOW_RESET = 32'd500000;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_WINDOW = 1'b0,
		REG_NONE   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CHECK,
		ST_DONE
	} eng_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] timestamp_us;
		logic [IP_W-1:0]   src_ip;
		logic [MAC_W-1:0]  src_mac;
		logic [15:0]       arp_opcode;
		logic [7:0]        proto_addr_len;
		logic [7:0]        hw_addr_len;
		logic [15:0]       protocol_type;
		logic [15:0]       hardware_type;
		logic [15:0]       packet_length;
	} pkt_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] entry_count;
		logic [IDX_OUT_W-1:0] entry_index;
		logic                 table_full;
		logic                 unsolicited_alert;
		logic                 rapid_change_alert;
		logic                 mac_changed;
		logic                 new_entry;
		logic                 known_address;
		logic                 accepted;
	} res_t;

	// Table access request from the engine to both memories.
	typedef struct packed {
		logic             en;
		logic             ip_we;
		logic             md_we;
		logic [IDX_W-1:0] addr;
		logic [IP_W-1:0]  ip_wdata;
		logic [MD_W-1:0]  md_wdata;
	} mem_req_t;

endpackage

// ===== src/arp_rsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_rsm_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module arp_rsm_ram #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== src/arp_rsm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_rsm_engine
// Packet check, pipelined table search and read-modify-write of one binding.
// ----------------------------------------------------------------------------
module arp_rsm_engine
	import arp_rsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pkt_t             in_pkt,
	input  logic [31:0]      window_us,
	output mem_req_t         mem,
	input  logic [IP_W-1:0]  ip_rdata,
	input  logic [MD_W-1:0]  md_rdata,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	eng_state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  issue_q;
	logic              cmp_v_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic [MAC_W-1:0]  mac_q;
	logic [IP_W-1:0]   ip_q;
	logic [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              chg_q;
	logic [63:0]       delta_q;
	res_t              res_q;
	res_t              res_d;

	logic well_formed;
	logic rd_en;
	logic match;
	logic search_end;
	logic has_room;

	assign well_formed = (in_pkt.packet_length >= MIN_PACKET_LEN) &&
		(in_pkt.hardware_type == HW_ETHERNET) && (in_pkt.protocol_type == PROTO_IPV4) &&
		(in_pkt.hw_addr_len == HW_ADDR_LEN) && (in_pkt.proto_addr_len == PROTO_ADDR_LEN) &&
		(in_pkt.arp_opcode == OP_REPLY);

	assign rd_en      = (state_q == ST_SEARCH) && (issue_q < count_q);
	assign match      = cmp_v_s1 && (ip_rdata == ip_q);
	assign search_end = !match && (issue_q == count_q);
	assign has_room   = count_q < CNT_W'(TABLE_ENTRIES);
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		res_valid    = 1'b0;
		mem          = '0;
		mem.ip_wdata = ip_q;
		mem.md_wdata = {now_q, mac_q};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = well_formed ? ST_SEARCH : ST_DONE;
				end
			end
			ST_SEARCH: begin
				mem.en   = rd_en;
				mem.addr = issue_q[IDX_W-1:0];
				if (match) begin
					state_d = ST_CHECK;
				end else if (search_end) begin
					state_d = ST_DONE;
					if (has_room) begin
						mem.en    = 1'b1;
						mem.ip_we = 1'b1;
						mem.md_we = 1'b1;
						mem.addr  = count_q[IDX_W-1:0];
					end
				end
			end
			ST_CHECK: begin
				state_d = ST_DONE;
				if (chg_q) begin
					mem.en    = 1'b1;
					mem.md_we = 1'b1;
					mem.addr  = hit_idx_q;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Verdict under construction for the packet in flight.
	always_comb begin
		res_d = res_q;
		if (state_q == ST_IDLE && in_valid) begin
			res_d             = '0;
			res_d.accepted    = well_formed;
			res_d.entry_count = CNT_OUT_W'(count_q);
		end
		if (state_q == ST_SEARCH) begin
			if (match) begin
				res_d.known_address     = 1'b1;
				res_d.unsolicited_alert = 1'b1;
				res_d.entry_index       = IDX_OUT_W'(cmp_idx_s1);
			end else if (search_end) begin
				if (has_room) begin
					res_d.new_entry         = 1'b1;
					res_d.unsolicited_alert = 1'b1;
					res_d.entry_index       = IDX_OUT_W'(count_q);
					res_d.entry_count       = CNT_OUT_W'(count_q + CNT_W'(1));
				end else begin
					res_d.table_full = 1'b1;
				end
			end
		end
		if (state_q == ST_CHECK && chg_q) begin
			res_d.mac_changed        = 1'b1;
			res_d.rapid_change_alert = $signed(delta_q) < $signed({32'b0, window_us});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			cmp_v_s1 <= rd_en;
			if (state_q == ST_SEARCH && search_end && has_room) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= issue_q[IDX_W-1:0];
		res_q      <= res_d;
		if (state_q == ST_IDLE && in_valid) begin
			mac_q   <= in_pkt.src_mac;
			ip_q    <= in_pkt.src_ip;
			now_q   <= in_pkt.timestamp_us;
			issue_q <= '0;
		end
		if (state_q == ST_SEARCH) begin
			issue_q <= issue_q + CNT_W'(rd_en);
			if (match) begin
				hit_idx_q <= cmp_idx_s1;
				chg_q     <= md_rdata[MAC_W-1:0] != mac_q;
				delta_q   <= {1'b0, now_q} - {1'b0, md_rdata[MD_W-1:MAC_W]};
			end
		end
	end

endmodule

// ===== src/arp_reply_spoof_monitor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_reply_spoof_monitor_core
// Watches received ARP replies against a table of IPv4-to-MAC bindings.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Width  Contents
//  s_axis    in    224    one parsed ARP packet per beat
//  m_axis    out   24     one verdict per packet
//  apb       in    32     rapid-change window register (address 0)
//
//  The search reads one IP entry per cycle from the single-ported IP memory
//  and compares it in the cycle after the read. Reset clears the binding count
//  and returns the window register to 500000 us; table memories are not
//  cleared, since only entries below the count are ever read.
//  A verdict waiting on m_axis does not block the next packet from entering;
//  only the completion of that next packet waits for the output to drain.
//
module arp_reply_spoof_monitor_core
	import arp_rsm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,

	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// packet_length[15:0], hardware_type[31:16], protocol_type[47:32],
	// hw_addr_len[55:48], proto_addr_len[63:56], arp_opcode[79:64],
	// src_mac[127:80], src_ip[159:128], timestamp_us[222:160], pad[223]
	input  logic [223:0] s_axis_tdata,

	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// accepted[0], known_address[1], new_entry[2], mac_changed[3],
	// rapid_change_alert[4], unsolicited_alert[5], table_full[6],
	// entry_index[12:7], entry_count[19:13], pad[23:20]
	output logic [23:0]  m_axis_tdata,

	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [31:0] window_q;
	reg_idx_t    reg_sel;

	pkt_t     pkt;
	mem_req_t mem;
	res_t     res;
	logic     res_valid;
	logic     res_ready;

	logic [IP_W-1:0] ip_rdata;
	logic [MD_W-1:0] md_rdata;

	logic        out_valid_q;
	logic [23:0] out_data_q;

	// Configuration port. Word 0 holds the window; other words read as zero and
	// ignore writes.
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_WINDOW) begin
			window_q <= pwdata;
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_WINDOW: prdata = window_q;
			REG_NONE:   prdata = '0;
			default:    prdata = '0;
		endcase
	end

	// The packed fields of the input beat line up with the packet struct.
	assign pkt = pkt_t'(s_axis_tdata[$bits(pkt_t)-1:0]);

	arp_rsm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pkt    (pkt),
		.window_us (window_q),
		.mem       (mem),
		.ip_rdata  (ip_rdata),
		.md_rdata  (md_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// IP column, scanned during the search.
	arp_rsm_ram #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (IP_W)
	) u_ip_ram (
		.clk   (clk),
		.en    (mem.en),
		.we    (mem.ip_we),
		.addr  (mem.addr),
		.wdata (mem.ip_wdata),
		.rdata (ip_rdata)
	);

	// MAC and change-time column, read alongside the IP column so the data of a
	// matching entry is on hand the same cycle the match is seen.
	arp_rsm_ram #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (MD_W)
	) u_md_ram (
		.clk   (clk),
		.en    (mem.en),
		.we    (mem.md_we),
		.addr  (mem.addr),
		.wdata (mem.md_wdata),
		.rdata (md_rdata)
	);

	// Output register. It takes a new verdict whenever it is empty or its beat
	// is being taken in the same cycle.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= {(24 - $bits(res_t))'(0), res};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== src/arp_rsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_rsm_checker
// Port-level checks on the verdict stream of the monitor.
// ----------------------------------------------------------------------------
module arp_rsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// A stalled verdict beat stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	else $error("verdict beat changed while stalled");

	// A rejected packet reports nothing but the count.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[12:1] == 12'd0)
	else $error("rejected packet carries flags or index");

	// An unsolicited reply is exactly a hit or an insert, never both; table_full excludes it.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[5] == (m_axis_tdata[1] || m_axis_tdata[2])) &&
			!(m_axis_tdata[1] && m_axis_tdata[2]) && !(m_axis_tdata[6] && m_axis_tdata[5]))
	else $error("inconsistent hit, insert and full flags");

	// A rapid change is a MAC change, and a MAC change needs a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3] && m_axis_tdata[1])
	else $error("rapid-change alert without a MAC change on a known entry");

endmodule

bind arp_reply_spoof_monitor_core arp_rsm_checker u_checker (.*);

// ===== test/arp_reply_spoof_monitor_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_reply_spoof_monitor_core_tb
// Self-checking bench for the ARP reply spoofing monitor.
// ----------------------------------------------------------------------------
//
// Parsed ARP packets go in on the slave stream while a local copy of the
// binding table works out the verdict each packet must produce. Every verdict
// beat on the master stream is checked field by field against the oldest
// outstanding prediction. Directed packets cover the header filters and the
// table update rules around the rapid-change window boundary. Random traffic
// then runs under several window settings, the extremes among them, until the
// table overflows. The sender works in bursts with random gaps, and the
// receiver stalls on a pattern of its own.
//
module arp_reply_spoof_monitor_core_tb;
	import arp_rsm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = TABLE_ENTRIES + 8;
	localparam int POOL_SIZE   = 80;

	// Byte addresses of the register file; the second one holds nothing.
	localparam logic [2:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
	localparam logic [2:0] ADDR_UNUSED = {REG_NONE, 2'b00};

	localparam logic [62:0] STAMP_MAX = {63{1'b1}};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// packet_length[15:0], hardware_type[31:16], protocol_type[47:32],
	// hw_addr_len[55:48], proto_addr_len[63:56], arp_opcode[79:64],
	// src_mac[127:80], src_ip[159:128], timestamp_us[222:160], pad[223]
	logic [223:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// accepted[0], known_address[1], new_entry[2], mac_changed[3],
	// rapid_change_alert[4], unsolicited_alert[5], table_full[6],
	// entry_index[12:7], entry_count[19:13], pad[23:20]
	logic [23:0]  m_axis_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	arp_reply_spoof_monitor_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the binding table and of the window register.
	logic [31:0] ip_tab [TABLE_ENTRIES];
	logic [47:0] mac_tab [TABLE_ENTRIES];
	logic [62:0] chg_tab [TABLE_ENTRIES];
	int          bind_cnt = 0;
	logic [31:0] win_us = WINDOW_RESET;

	// Verdicts predicted for the packets sent, oldest first.
	res_t pending_verdicts [$];

	int errors = 0;
	int cycle_cnt = 0;

	// Sender pacing.
	int burst_left = 0;
	bit pace_gaps = 1'b1;

	// Random traffic: a pool of addresses that keep coming back, and a clock.
	logic [31:0] ip_pool [POOL_SIZE];
	logic [47:0] pool_mac [POOL_SIZE];
	logic [62:0] now_us = 63'd1000000;

	// Tallies for the closing summary.
	int n_packets = 0;
	int n_accepted = 0;
	int n_inserts = 0;
	int n_hits = 0;
	int n_changes = 0;
	int n_rapid = 0;
	int n_full = 0;
	int n_windows = 0;

	// Receiver pacing state.
	int rx_hold = 0;
	int rx_mode = 0;

	// Works out the verdict of one packet and applies it to the local table.
	function automatic res_t predict_verdict(input pkt_t p);
		res_t   r;
		int     i;
		int     hit_at;
		longint delta;
		longint limit;
		r = '0;
		hit_at = -1;
		if (p.packet_length >= MIN_PACKET_LEN && p.hardware_type == HW_ETHERNET &&
				p.protocol_type == PROTO_IPV4 && p.hw_addr_len == HW_ADDR_LEN &&
				p.proto_addr_len == PROTO_ADDR_LEN && p.arp_opcode == OP_REPLY) begin
			r.accepted = 1'b1;
			// The first matching entry wins.
			for (i = 0; i < bind_cnt; i++) begin
				if (hit_at < 0 && ip_tab[i] == p.src_ip)
					hit_at = i;
			end
			if (hit_at >= 0) begin
				r.known_address = 1'b1;
				r.unsolicited_alert = 1'b1;
				r.entry_index = IDX_OUT_W'(hit_at);
				if (mac_tab[hit_at] != p.src_mac) begin
					// Both stamps are below 2^63, so the signed difference is exact.
					delta = longint'({1'b0, p.timestamp_us}) - longint'({1'b0, chg_tab[hit_at]});
					limit = longint'({32'b0, win_us});
					r.mac_changed = 1'b1;
					r.rapid_change_alert = (delta < limit);
					mac_tab[hit_at] = p.src_mac;
					chg_tab[hit_at] = p.timestamp_us;
				end
			end else if (bind_cnt < TABLE_ENTRIES) begin
				ip_tab[bind_cnt] = p.src_ip;
				mac_tab[bind_cnt] = p.src_mac;
				chg_tab[bind_cnt] = p.timestamp_us;
				r.new_entry = 1'b1;
				r.unsolicited_alert = 1'b1;
				r.entry_index = IDX_OUT_W'(bind_cnt);
				bind_cnt++;
			end else begin
				r.table_full = 1'b1;
			end
		end
		r.entry_count = CNT_OUT_W'(bind_cnt);
		return r;
	endfunction

	function automatic pkt_t arp_reply(input logic [31:0] ip, input logic [47:0] mac,
			input logic [62:0] stamp);
		pkt_t p;
		p.packet_length = MIN_PACKET_LEN;
		p.hardware_type = HW_ETHERNET;
		p.protocol_type = PROTO_IPV4;
		p.hw_addr_len = HW_ADDR_LEN;
		p.proto_addr_len = PROTO_ADDR_LEN;
		p.arp_opcode = OP_REPLY;
		p.src_mac = mac;
		p.src_ip = ip;
		p.timestamp_us = stamp;
		return p;
	endfunction

	function automatic logic [47:0] random_mac();
		return 48'({$urandom(), $urandom()});
	endfunction

	// Sends one packet beat, opening a new burst after a random gap when the
	// previous one is used up. Called at a rising edge; returns at the edge
	// where the beat was taken.
	task automatic send_packet(input pkt_t p);
		res_t r;
		int   gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = pace_gaps ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, p};
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = predict_verdict(p);
		pending_verdicts.push_back(r);
		n_packets++;
		n_accepted += r.accepted;
		n_inserts += r.new_entry;
		n_hits += r.known_address;
		n_changes += r.mac_changed;
		n_rapid += r.rapid_change_alert;
		n_full += r.table_full;
	endtask

	// Leaves the block idle: no packet offered and no verdict outstanding.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_WINDOW) begin
			win_us = value;
			n_windows++;
		end
	endtask

	task automatic check_reg(input logic [2:0] addr, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$display("%0t ns: register %0d read expected %0h, actual %0h",
				$time, addr, want, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic compare_field(input string name, input logic [6:0] want,
			input logic [6:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Moves the packet clock on: mostly small steps, sometimes long ones, now
	// and then backwards or to an arbitrary point. It wraps within 63 bits.
	task automatic advance_clock();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: now_us = now_us + 63'($urandom_range(0, 2000));
			5, 6: now_us = now_us + 63'($urandom_range(0, 3000000));
			7: now_us = now_us - 63'($urandom_range(0, 1000000));
			8: now_us = 63'({$urandom(), $urandom()});
			default: now_us = now_us + 63'($urandom());
		endcase
	endtask

	// Every verdict beat is checked against the oldest prediction.
	always @(posedge clk) begin : verdict_check
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
			if (pending_verdicts.size() == 0) begin
				$display("%0t ns: verdict beat %0h arrived with none expected",
					$time, got);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				compare_field("accepted", want.accepted, got.accepted);
				compare_field("known_address", want.known_address, got.known_address);
				compare_field("new_entry", want.new_entry, got.new_entry);
				compare_field("mac_changed", want.mac_changed, got.mac_changed);
				compare_field("rapid_change_alert", want.rapid_change_alert,
					got.rapid_change_alert);
				compare_field("unsolicited_alert", want.unsolicited_alert,
					got.unsolicited_alert);
				compare_field("table_full", want.table_full, got.table_full);
				compare_field("entry_index", want.entry_index, got.entry_index);
				compare_field("entry_count", want.entry_count, got.entry_count);
			end
		end
	end

	// The receiver alternates between steady acceptance, long stalls and a
	// choppy stretch where ready follows a coin toss.
	always @(posedge clk) begin : sink_pacing
		if (rx_hold == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_hold = (rx_mode == 1) ? $urandom_range(1, 20) : $urandom_range(1, 60);
		end
		rx_hold--;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'b0;
			default: m_axis_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin : watchdog
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The window register must come out of reset at its default.
	task automatic test_reset_window();
		check_reg(ADDR_WINDOW, WINDOW_RESET);
	endtask

	// One broken header field at a time, then the shortest and longest lengths
	// that pass. The first accepted reply starts the table.
	task automatic test_header_filters();
		pkt_t base;
		pkt_t p;
		base = arp_reply(32'hC0A8_0101, 48'h0011_2233_4455, 63'd1000000);
		p = base;
		p.packet_length = MIN_PACKET_LEN - 16'd1;
		send_packet(p);
		p = base;
		p.hardware_type = 16'h0000;
		send_packet(p);
		p = base;
		p.protocol_type = 16'h86DD;
		send_packet(p);
		p = base;
		p.hw_addr_len = 8'hFF;
		send_packet(p);
		p = base;
		p.proto_addr_len = 8'h00;
		send_packet(p);
		p = base;
		p.arp_opcode = 16'h0001;
		send_packet(p);
		send_packet(base);
		p = base;
		p.packet_length = 16'hFFFF;
		p.timestamp_us = 63'd1000010;
		send_packet(p);
	endtask

	// Inserts at the address extremes, then MAC changes just inside, on and
	// past the window edge, a repeat of the same MAC, and a clock running
	// backwards.
	task automatic test_binding_updates();
		logic [31:0] ip_a;
		logic [62:0] t;
		ip_a = 32'hC0A8_0101;
		t = 63'd1000000;
		send_packet(arp_reply(32'h0000_0000, 48'h0, 63'd0));
		send_packet(arp_reply(32'hFFFF_FFFF, {48{1'b1}}, STAMP_MAX));
		t = t + 63'd100;
		send_packet(arp_reply(ip_a, 48'h0011_2233_4466, t));
		t = t + 63'(WINDOW_RESET);
		send_packet(arp_reply(ip_a, 48'h0011_2233_4477, t));
		t = t + 63'(WINDOW_RESET) - 63'd1;
		send_packet(arp_reply(ip_a, 48'h0011_2233_4488, t));
		send_packet(arp_reply(ip_a, 48'h0011_2233_4488, t + 63'd900000));
		send_packet(arp_reply(32'hFFFF_FFFF, 48'h1234_5678_9ABC, 63'd5));
		send_packet(arp_reply(32'h0000_0000, 48'h0000_0000_0001, STAMP_MAX));
	endtask

	// Window at zero and at its top, around the edge each time, and a write
	// to an address with no register behind it.
	task automatic test_window_register();
		logic [31:0] ip_a;
		logic [62:0] t;
		ip_a = 32'hC0A8_0101;
		t = chg_tab[0];
		wait_drained();
		write_reg(ADDR_WINDOW, 32'h0000_0000);
		check_reg(ADDR_WINDOW, 32'h0000_0000);
		send_packet(arp_reply(ip_a, 48'hA0A0_A0A0_A0A0, t));
		t = t - 63'd1;
		send_packet(arp_reply(ip_a, 48'hB0B0_B0B0_B0B0, t));
		wait_drained();
		write_reg(ADDR_WINDOW, 32'hFFFF_FFFF);
		t = t + 63'h0_FFFF_FFFE;
		send_packet(arp_reply(ip_a, 48'hC0C0_C0C0_C0C0, t));
		t = t + 63'h0_FFFF_FFFF;
		send_packet(arp_reply(ip_a, 48'hD0D0_D0D0_D0D0, t));
		wait_drained();
		write_reg(ADDR_UNUSED, 32'h0000_1234);
		check_reg(ADDR_WINDOW, 32'hFFFF_FFFF);
	endtask

	// One window setting with random traffic. Most packets are well-formed
	// replies from a pool of returning addresses, so bindings get hit and
	// their MACs flap; the rest are new addresses, replies with one header
	// field broken, and pure noise.
	task automatic test_random_phase(input logic [31:0] window, input int replies,
			input bit gaps);
		pkt_t         p;
		logic [223:0] noise;
		int           sent;
		int           pick;
		int           slot;
		wait_drained();
		write_reg(ADDR_WINDOW, window);
		pace_gaps = gaps;
		sent = 0;
		while (sent < replies) begin
			pick = $urandom_range(0, 99);
			slot = $urandom_range(0, POOL_SIZE - 1);
			advance_clock();
			if (pick < 90 && $urandom_range(0, 99) >= 55)
				pool_mac[slot] = random_mac();
			if (pick < 70 || (pick >= 78 && pick < 90))
				p = arp_reply(ip_pool[slot], pool_mac[slot], now_us);
			else
				p = arp_reply($urandom(), random_mac(), now_us);
			p.packet_length = ($urandom_range(0, 6) == 0) ?
				16'($urandom_range(28, 65535)) : 16'($urandom_range(28, 128));
			if (pick >= 78 && pick < 90) begin
				case ($urandom_range(0, 5))
					0: p.packet_length = 16'($urandom_range(0, 27));
					1: p.hardware_type = 16'($urandom());
					2: p.protocol_type = 16'($urandom());
					3: p.hw_addr_len = 8'($urandom());
					4: p.proto_addr_len = 8'($urandom());
					default: p.arp_opcode = 16'($urandom());
				endcase
			end else if (pick >= 90) begin
				noise = {$urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom()};
				p = pkt_t'(noise[$bits(pkt_t)-1:0]);
			end
			send_packet(p);
			if (pick < 78)
				sent++;
		end
	endtask

	// Fill whatever room is left, then offer unknown addresses to a full table
	// and change the MAC of the last entry.
	task automatic test_table_full();
		logic [62:0] t;
		pace_gaps = 1'b1;
		while (bind_cnt < TABLE_ENTRIES) begin
			advance_clock();
			send_packet(arp_reply($urandom(), random_mac(), now_us));
		end
		repeat (3) begin
			advance_clock();
			send_packet(arp_reply($urandom(), random_mac(), now_us));
		end
		t = chg_tab[TABLE_ENTRIES - 1] + 63'd1;
		send_packet(arp_reply(ip_tab[TABLE_ENTRIES - 1], ~mac_tab[TABLE_ENTRIES - 1], t));
	endtask

	initial begin
		int k;
		for (k = 0; k < POOL_SIZE; k++) begin
			ip_pool[k] = $urandom();
			pool_mac[k] = random_mac();
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_header_filters();
		test_binding_updates();
		test_window_register();
		test_random_phase(32'($urandom_range(1000, 2000000)), 175, 1'b1);
		test_random_phase(32'h0000_0000, 175, 1'b0);
		test_random_phase(32'hFFFF_FFFF, 175, 1'b1);
		test_random_phase($urandom(), 175, 1'b1);
		test_table_full();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d packets (%0d accepted) over %0d window settings.",
			n_packets, n_accepted, n_windows);
		$display("Verdicts: %0d inserts, %0d hits, %0d MAC changes (%0d rapid), %0d dropped.",
			n_inserts, n_hits, n_changes, n_rapid, n_full);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
